>>> hdl/mu8d_pkg.sv
// shared status codes and result type for the modified utf-8 byte decoder
`timescale 1ns / 1ps

package mu8d_pkg;

   localparam logic [1:0] ST_OK        = 2'd0;
   localparam logic [1:0] ST_TRUNCATED = 2'd1;
   localparam logic [1:0] ST_BAD_CONT  = 2'd2;
   localparam logic [1:0] ST_BAD_LEAD  = 2'd3;

   typedef struct packed {
      logic [7:0] char_out;
      logic [1:0] status;
      logic       end_of_string;
   } result_type;

endpackage

>>> hdl/modified_utf8_byte_decoder.sv
// modified utf-8 byte decoder: one byte per request, at most one character out
// a result passes from request accept through the input register and then the result register to rsp_valid
// throughput: one request per cycle while req_stall is low; the sequence state updates in a single pass
// req_stall rises only when the result register is held by rsp_stall and the input
// register is occupied
// synchronous active-high reset clears valids and sequence state
`timescale 1ns / 1ps

module modified_utf8_byte_decoder (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_stall,
   input  logic [7:0] req_byte_in,
   input  logic       req_is_last,
   output logic       rsp_valid,
   input  logic       rsp_stall,
   output logic [7:0] rsp_char_out,
   output logic [1:0] rsp_status,
   output logic       rsp_end_of_string
);
   import mu8d_pkg::*;

   // input register
   logic       in_valid_ff, in_valid_in;
   logic [7:0] in_byte_ff;
   logic       in_last_ff;

   // sequence state
   logic [1:0] pending_ff, pending_in;
   logic [1:0] partial_ff, partial_in;
   logic       bad_cont_ff, bad_cont_in;
   logic       discard_ff, discard_in;

   // result register
   logic       out_valid_ff, out_valid_in;
   result_type out_ff, out_in;

   logic       out_free;
   logic       advance;
   logic       emit;
   result_type res;
   logic       is_cont;

   assign out_free  = !out_valid_ff || !rsp_stall;
   assign advance   = in_valid_ff && out_free;
   assign req_stall = in_valid_ff && !out_free;
   assign is_cont   = (in_byte_ff[7:6] == 2'b10);

   always_comb begin
      emit        = 1'b0;
      res         = '{char_out: 8'd0, status: ST_OK, end_of_string: in_last_ff};
      pending_in  = pending_ff;
      partial_in  = partial_ff;
      bad_cont_in = bad_cont_ff;
      discard_in  = discard_ff;

      priority if (discard_ff) begin
         discard_in = !in_last_ff;
      end else if (pending_ff == 2'd0) begin
         priority if (!in_byte_ff[7]) begin
            emit         = 1'b1;
            res.char_out = in_byte_ff;
         end else if (in_byte_ff[7:5] == 3'b110) begin
            if (in_last_ff) begin
               emit       = 1'b1;
               res.status = ST_TRUNCATED;
            end else begin
               pending_in  = 2'd1;
               partial_in  = in_byte_ff[1:0];
               bad_cont_in = 1'b0;
            end
         end else if (in_byte_ff[7:4] == 4'hE) begin
            if (in_last_ff) begin
               emit       = 1'b1;
               res.status = ST_TRUNCATED;
            end else begin
               pending_in  = 2'd2;
               partial_in  = 2'd0;
               bad_cont_in = 1'b0;
            end
         end else begin
            // stray continuation or lead byte of 0xF0 and above (four-byte and longer leads)
            emit       = 1'b1;
            res.status = ST_BAD_LEAD;
         end
      end else if (pending_ff == 2'd1) begin
         emit = 1'b1;
         if (bad_cont_ff || !is_cont) begin
            res.status = ST_BAD_CONT;
         end else begin
            res.char_out = {partial_ff, in_byte_ff[5:0]};
            pending_in   = 2'd0;
            partial_in   = 2'd0;
            bad_cont_in  = 1'b0;
         end
      end else begin
         // middle byte of a three-byte sequence, truncation wins over a bad byte
         if (in_last_ff) begin
            emit       = 1'b1;
            res.status = ST_TRUNCATED;
         end else begin
            bad_cont_in = !is_cont;
            partial_in  = in_byte_ff[1:0];
            pending_in  = 2'd1;
         end
      end

      // any error clears the sequence and drops the rest of the string
      if (emit && (res.status != ST_OK)) begin
         res.end_of_string = 1'b1;
         pending_in        = 2'd0;
         partial_in        = 2'd0;
         bad_cont_in       = 1'b0;
         discard_in        = !in_last_ff;
      end
   end

   always_comb begin
      in_valid_in  = in_valid_ff;
      out_valid_in = out_valid_ff;
      out_in       = out_ff;
      if (out_free) begin
         out_valid_in = advance && emit;
         out_in       = res;
      end
      if (!req_stall) begin
         in_valid_in = req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
         pending_ff   <= 2'd0;
         partial_ff   <= 2'd0;
         bad_cont_ff  <= 1'b0;
         discard_ff   <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
         if (advance) begin
            pending_ff  <= pending_in;
            partial_ff  <= partial_in;
            bad_cont_ff <= bad_cont_in;
            discard_ff  <= discard_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (!req_stall) begin
         in_byte_ff <= req_byte_in;
         in_last_ff <= req_is_last;
      end
      out_ff <= out_in;
   end

   assign rsp_valid         = out_valid_ff;
   assign rsp_char_out      = out_ff.char_out;
   assign rsp_status        = out_ff.status;
   assign rsp_end_of_string = out_ff.end_of_string;

endmodule

>>> hdl/mu8d_checker.sv
// port-level checker for the modified utf-8 byte decoder, bound to the decoder module
`timescale 1ns / 1ps

module mu8d_checker (
   input logic       clock,
   input logic       reset,
   input logic       req_valid,
   input logic       req_stall,
   input logic       rsp_valid,
   input logic       rsp_stall,
   input logic [7:0] rsp_char_out,
   input logic [1:0] rsp_status,
   input logic       rsp_end_of_string
);
   import mu8d_pkg::*;

   // error results carry no character and close the string
   a_err_shape: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_status != ST_OK) |-> (rsp_char_out == 8'd0) && rsp_end_of_string)
      else $error("error result with nonzero char or without end of string");

   // an empty result register never back-pressures requests
   a_no_idle_stall: assert property (@(posedge clock) disable iff (reset)
      !rsp_valid |-> !req_stall)
      else $error("request stalled while result register empty");

   // a fresh result comes from a request that passed through the input register to the result register
   a_rose_from_req: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(req_valid && !req_stall, 2))
      else $error("result without a matching request");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_char_out)
         && $stable(rsp_status) && $stable(rsp_end_of_string))
      else $error("stalled result changed");

endmodule

bind modified_utf8_byte_decoder mu8d_checker u_mu8d_checker (
   .clock             (clock),
   .reset             (reset),
   .req_valid         (req_valid),
   .req_stall         (req_stall),
   .rsp_valid         (rsp_valid),
   .rsp_stall         (rsp_stall),
   .rsp_char_out      (rsp_char_out),
   .rsp_status        (rsp_status),
   .rsp_end_of_string (rsp_end_of_string)
);
